/* rtl/phc_pkg.sv */
// ============================================================================
// Pressure/humidity compensation package
// Shared constants, configuration register indexes, the divider stage type and its step function.
// ============================================================================
`default_nettype none

package phc_pkg;

    localparam int DIV_STAGES   = 32;
    localparam int DIV_STEP     = 64 / DIV_STAGES;
    localparam int FRONT_STAGES = 11;
    localparam int POST_STAGES  = 6;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + POST_STAGES;

    localparam logic [1:0] CFG_TEMP_TRIM  = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [1:0] CFG_HUM_TRIM   = 2'd3;

    localparam logic signed [26:0] TEMP_ROUND     = 27'sd128;
    localparam logic signed [24:0] PRESS_FINE_OFS = 25'sd128000;
    localparam logic [20:0]        PRESS_ADC_FULL = 21'd1048576;
    localparam logic [63:0]        PRESS_SCALE    = 64'd3125;
    localparam logic [63:0]        PRESS_ONE_Q47  = 64'h0000_8000_0000_0000;
    localparam logic signed [24:0] HUM_FINE_OFS   = 25'sd76800;
    localparam logic signed [38:0] HUM_ROUND_F1   = 39'sd16384;
    localparam logic signed [23:0] HUM_HALF       = 24'sd32768;
    localparam logic signed [37:0] HUM_BIAS       = 38'sd2097152;
    localparam logic signed [53:0] HUM_ROUND_F2   = 54'sd8192;
    localparam logic signed [33:0] HUM_MAX        = 34'sd419430400;
    localparam logic [16:0]        HUM_MAX_OUT    = 17'd102400;

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] nq;
        logic [30:0] ub;
        logic        neg;
        logic        zero;
        logic [18:0] temp;
        logic [23:0] fine;
        logic [16:0] hum;
    } div_stage_t;

    // Restoring division: the dividend shifts out of nq while quotient bits shift in.
    function automatic div_stage_t div_step(input div_stage_t st);
        div_stage_t  r;
        logic [31:0] t;
        r = st;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r.rem, r.nq[63]};
            if (t >= {1'b0, r.ub}) begin
                t = t - {1'b0, r.ub};
                r.nq = {r.nq[62:0], 1'b1};
            end else begin
                r.nq = {r.nq[62:0], 1'b0};
            end
            r.rem = t[30:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/pressure_humidity_compensation.sv */
// ============================================================================
// Pressure/humidity compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ============================================================================
// The block takes one word of raw readings per clock and returns one word of
// compensated results through eleven stages of temperature, humidity
// and pressure preparation, a 32-stage divider that retires two quotient bits
// per stage, and six stages of pressure correction and saturation. The whole
// pipeline advances whenever the output register is empty or being taken, so
// it sustains one word per cycle. Calibration registers must be written while
// no word is in flight.
`default_nettype none

module pressure_humidity_compensation
    import phc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_wr_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
    input  wire logic [55:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // temp_centi[31:0], fine_temp[63:32], press_q24_8[95:64], hum_q7_10[112:96]
    output logic [119:0]      m_axis_tdata,
    // press_valid[0]
    output logic [0:0]        m_axis_tuser
);

    logic [63:0] temp_trim_reg, press_low_reg, press_high_reg, hum_trim_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic adv;

    assign adv           = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg  <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            hum_trim_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TEMP_TRIM:  temp_trim_reg  <= cfg_wr_data;
                CFG_PRESS_LOW:  press_low_reg  <= cfg_wr_data;
                CFG_PRESS_HIGH: press_high_reg <= cfg_wr_data;
                CFG_HUM_TRIM:   hum_trim_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_trim_reg[15:0];
    assign t2 = $signed(temp_trim_reg[31:16]);
    assign t3 = $signed(temp_trim_reg[47:32]);
    assign p1 = temp_trim_reg[63:48];
    assign p2 = $signed(press_low_reg[15:0]);
    assign p3 = $signed(press_low_reg[31:16]);
    assign p4 = $signed(press_low_reg[47:32]);
    assign p5 = $signed(press_low_reg[63:48]);
    assign p6 = $signed(press_high_reg[15:0]);
    assign p7 = $signed(press_high_reg[31:16]);
    assign p8 = $signed(press_high_reg[47:32]);
    assign p9 = $signed(press_high_reg[63:48]);
    assign h1 = hum_trim_reg[7:0];
    assign h2 = $signed(hum_trim_reg[23:8]);
    assign h3 = hum_trim_reg[31:24];
    assign h4 = $signed(hum_trim_reg[43:32]);
    assign h5 = $signed(hum_trim_reg[55:44]);
    assign h6 = $signed(hum_trim_reg[63:56]);

    // Stage 1: temperature products.
    logic signed [17:0] s1_tdiff;
    logic signed [16:0] s1_d;
    logic signed [32:0] s1_dd_full;
    logic signed [33:0] s1_ta_next, s1_ta_reg;
    logic [31:0]        s1_dd_reg;
    logic [19:0]        s1_ap_reg;
    logic [15:0]        s1_ah_reg;

    assign s1_tdiff   = $signed({1'b0, s_axis_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_d       = $signed({1'b0, s_axis_tdata[19:4]}) - $signed({1'b0, t1});
    assign s1_dd_full = s1_d * s1_d;
    assign s1_ta_next = s1_tdiff * t2;

    // Stage 2 and 3: fine temperature.
    logic signed [22:0] s2_a_reg;
    logic signed [36:0] s2_b_next, s2_b_reg;
    logic [19:0]        s2_ap_reg, s3_ap_reg;
    logic [15:0]        s2_ah_reg, s3_ah_reg;
    logic signed [23:0] s3_fine_next, s3_fine_reg;

    assign s2_b_next    = $signed({1'b0, s1_dd_reg[31:12]}) * t3;
    assign s3_fine_next = s2_a_reg + $signed(s2_b_reg[36:14]);

    // Stage 4: temperature output, first pressure and humidity products.
    logic signed [26:0] s4_t5;
    logic signed [24:0] s4_x1, s4_v;
    logic signed [18:0] s4_temp_reg;
    logic signed [23:0] s4_fine_reg;
    logic signed [48:0] s4_x1sq_next, s4_x1sq_reg;
    logic signed [40:0] s4_x1p5_next, s4_x1p5_reg, s4_x1p2_next, s4_x1p2_reg;
    logic signed [38:0] s4_ha_next, s4_ha_reg;
    logic signed [32:0] s4_hb_next, s4_hb_reg;
    logic signed [33:0] s4_hc_next, s4_hc_reg;
    logic [19:0]        s4_ap_reg;

    assign s4_t5        = s3_fine_reg * 27'sd5 + TEMP_ROUND;
    assign s4_x1        = s3_fine_reg - PRESS_FINE_OFS;
    assign s4_v         = s3_fine_reg - HUM_FINE_OFS;
    assign s4_x1sq_next = s4_x1 * s4_x1;
    assign s4_x1p5_next = s4_x1 * p5;
    assign s4_x1p2_next = s4_x1 * p2;
    assign s4_ha_next   = $signed({1'b0, s3_ah_reg, 14'd0}) - $signed({h4, 20'd0})
                          - h5 * s4_v + HUM_ROUND_F1;
    assign s4_hb_next   = s4_v * h6;
    assign s4_hc_next   = s4_v * $signed({1'b0, h3});

    // Stage 5.
    logic signed [18:0] s5_temp_reg;
    logic signed [23:0] s5_fine_reg;
    logic signed [63:0] s5_x2a_next, s5_x2a_reg, s5_x1a_next, s5_x1a_reg;
    logic signed [40:0] s5_x1p5_reg, s5_x1p2_reg;
    logic [19:0]        s5_ap_reg;
    logic signed [23:0] s5_f1_reg;
    logic signed [23:0] s5_hc_sum;
    logic signed [46:0] s5_hd_next, s5_hd_reg;

    assign s5_x2a_next = s4_x1sq_reg * p6;
    assign s5_x1a_next = s4_x1sq_reg * p3;
    assign s5_hc_sum   = $signed(s4_hc_reg[33:11]) + HUM_HALF;
    assign s5_hd_next  = $signed(s4_hb_reg[32:10]) * s5_hc_sum;

    // Stage 6.
    logic signed [18:0] s6_temp_reg;
    logic signed [23:0] s6_fine_reg;
    logic [63:0]        s6_x2_next, s6_x2_reg, s6_xs_next, s6_xs_reg;
    logic [19:0]        s6_ap_reg;
    logic signed [23:0] s6_f1_reg;
    logic signed [37:0] s6_hd_sum;
    logic signed [53:0] s6_he_next, s6_he_reg;

    assign s6_x2_next = s5_x2a_reg + $signed({s5_x1p5_reg, 17'd0}) + $signed({p4, 35'd0});
    assign s6_xs_next = $signed(s5_x1a_reg[63:8]) + $signed({s5_x1p2_reg, 12'd0})
                        + $signed(PRESS_ONE_Q47);
    assign s6_hd_sum  = $signed(s5_hd_reg[46:10]) + HUM_BIAS;
    assign s6_he_next = s6_hd_sum * h2;

    // Stage 7.
    logic signed [18:0] s7_temp_reg;
    logic signed [23:0] s7_fine_reg;
    logic [20:0]        s7_pa;
    logic [63:0]        s7_xp_next, s7_xp_reg, s7_num_next, s7_num_reg;
    logic signed [23:0] s7_f1_reg;
    logic signed [53:0] s7_he_sum;
    logic [31:0]        s7_f2_reg;

    assign s7_pa       = PRESS_ADC_FULL - {1'b0, s6_ap_reg};
    assign s7_xp_next  = s6_xs_reg * {48'd0, p1};
    assign s7_num_next = {12'd0, s7_pa, 31'd0} - s6_x2_reg;
    assign s7_he_sum   = s6_he_reg + HUM_ROUND_F2;

    // Stage 8.
    logic signed [18:0] s8_temp_reg;
    logic signed [23:0] s8_fine_reg;
    logic [30:0]        s8_divx_reg;
    logic [63:0]        s8_dvd_next, s8_dvd_reg;
    logic [31:0]        s8_hv_next, s8_hv_reg;

    assign s8_dvd_next = s7_num_reg * PRESS_SCALE;
    assign s8_hv_next  = {{8{s7_f1_reg[23]}}, s7_f1_reg} * s7_f2_reg;

    // Stage 9: divider operands, humidity correction square.
    logic signed [18:0] s9_temp_reg;
    logic signed [23:0] s9_fine_reg;
    logic [63:0]        s9_ua_reg;
    logic [30:0]        s9_ub_reg;
    logic               s9_neg_reg, s9_zero_reg;
    logic [31:0]        s9_hv_reg;
    logic signed [16:0] s9_q;
    logic signed [33:0] s9_qq_full;
    logic [32:0]        s9_qq_reg;

    assign s9_q       = $signed(s8_hv_reg[31:15]);
    assign s9_qq_full = s9_q * s9_q;

    // Stage 10.
    logic signed [18:0] s10_temp_reg;
    logic signed [23:0] s10_fine_reg;
    logic [63:0]        s10_ua_reg;
    logic [30:0]        s10_ub_reg;
    logic               s10_neg_reg, s10_zero_reg;
    logic [31:0]        s10_hv_reg;
    logic [33:0]        s10_hq_next, s10_hq_reg;

    assign s10_hq_next = s9_qq_reg[32:7] * h1;

    // Stage 11: humidity finish, divider entry.
    logic signed [33:0] s11_hv2;
    logic [16:0]        s11_hum;
    div_stage_t         s11_next;
    div_stage_t         dv_reg [DIV_STAGES+1];

    assign s11_hv2 = $signed({{2{s10_hv_reg[31]}}, s10_hv_reg})
                     - $signed({4'd0, s10_hq_reg[33:4]});

    always_comb begin
        if (s11_hv2 < 0) begin
            s11_hum = '0;
        end else if (s11_hv2 > HUM_MAX) begin
            s11_hum = HUM_MAX_OUT;
        end else begin
            s11_hum = s11_hv2[28:12];
        end
        s11_next      = '0;
        s11_next.nq   = s10_ua_reg;
        s11_next.ub   = s10_ub_reg;
        s11_next.neg  = s10_neg_reg;
        s11_next.zero = s10_zero_reg;
        s11_next.temp = s10_temp_reg;
        s11_next.fine = s10_fine_reg;
        s11_next.hum  = s11_hum;
    end

    // Post-division pressure correction.
    div_stage_t         dv_last;
    logic signed [63:0] p1_p_reg, p2_p_reg, p3_p_reg, p4_p_reg;
    logic signed [50:0] p2_ps;
    logic [63:0]        p3_b64;
    logic signed [63:0] p2_y1a_next, p2_y1a_reg, p2_p8p_next, p2_p8p_reg, p3_p8p_reg;
    logic [63:0]        p3_pp0_reg;
    logic [31:0]        p3_pp1_reg, p3_pp2_reg;
    logic [63:0]        p4_y1full;
    logic signed [38:0] p4_y1_reg;
    logic signed [44:0] p4_y2_reg;
    logic signed [63:0] p5_sum, p5_r_next, p5_r_reg;
    logic [18:0]        p1_temp_reg, p2_temp_reg, p3_temp_reg, p4_temp_reg, p5_temp_reg;
    logic [23:0]        p1_fine_reg, p2_fine_reg, p3_fine_reg, p4_fine_reg, p5_fine_reg;
    logic [16:0]        p1_hum_reg, p2_hum_reg, p3_hum_reg, p4_hum_reg, p5_hum_reg;
    logic               p1_zero_reg, p2_zero_reg, p3_zero_reg, p4_zero_reg, p5_zero_reg;
    logic [31:0]        out_press_next, out_press_reg;
    logic [18:0]        out_temp_reg;
    logic [23:0]        out_fine_reg;
    logic [16:0]        out_hum_reg;
    logic               out_pvalid_reg;

    assign dv_last     = dv_reg[DIV_STAGES];
    assign p2_ps       = $signed(p1_p_reg[63:13]);
    assign p2_y1a_next = p9 * p2_ps;
    assign p2_p8p_next = p8 * p1_p_reg;
    assign p3_b64      = {{13{p2_p_reg[63]}}, p2_p_reg[63:13]};
    assign p4_y1full   = p3_pp0_reg + {p3_pp1_reg + p3_pp2_reg, 32'd0};
    assign p5_sum      = p4_p_reg + p4_y1_reg + p4_y2_reg;
    assign p5_r_next   = $signed(p5_sum[63:8]) + $signed({p7, 4'd0});

    always_comb begin
        if (p5_zero_reg || p5_r_reg < 0) begin
            out_press_next = '0;
        end else if (p5_r_reg[63:32] != 32'd0) begin
            out_press_next = '1;
        end else begin
            out_press_next = p5_r_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ta_reg    <= s1_ta_next;
            s1_dd_reg    <= s1_dd_full[31:0];
            s1_ap_reg    <= s_axis_tdata[39:20];
            s1_ah_reg    <= s_axis_tdata[55:40];

            s2_a_reg     <= $signed(s1_ta_reg[33:11]);
            s2_b_reg     <= s2_b_next;
            s2_ap_reg    <= s1_ap_reg;
            s2_ah_reg    <= s1_ah_reg;

            s3_fine_reg  <= s3_fine_next;
            s3_ap_reg    <= s2_ap_reg;
            s3_ah_reg    <= s2_ah_reg;

            s4_temp_reg  <= $signed(s4_t5[26:8]);
            s4_fine_reg  <= s3_fine_reg;
            s4_x1sq_reg  <= s4_x1sq_next;
            s4_x1p5_reg  <= s4_x1p5_next;
            s4_x1p2_reg  <= s4_x1p2_next;
            s4_ha_reg    <= s4_ha_next;
            s4_hb_reg    <= s4_hb_next;
            s4_hc_reg    <= s4_hc_next;
            s4_ap_reg    <= s3_ap_reg;

            s5_temp_reg  <= s4_temp_reg;
            s5_fine_reg  <= s4_fine_reg;
            s5_x2a_reg   <= s5_x2a_next;
            s5_x1a_reg   <= s5_x1a_next;
            s5_x1p5_reg  <= s4_x1p5_reg;
            s5_x1p2_reg  <= s4_x1p2_reg;
            s5_ap_reg    <= s4_ap_reg;
            s5_f1_reg    <= $signed(s4_ha_reg[38:15]);
            s5_hd_reg    <= s5_hd_next;

            s6_temp_reg  <= s5_temp_reg;
            s6_fine_reg  <= s5_fine_reg;
            s6_x2_reg    <= s6_x2_next;
            s6_xs_reg    <= s6_xs_next;
            s6_ap_reg    <= s5_ap_reg;
            s6_f1_reg    <= s5_f1_reg;
            s6_he_reg    <= s6_he_next;

            s7_temp_reg  <= s6_temp_reg;
            s7_fine_reg  <= s6_fine_reg;
            s7_xp_reg    <= s7_xp_next;
            s7_num_reg   <= s7_num_next;
            s7_f1_reg    <= s6_f1_reg;
            s7_f2_reg    <= s7_he_sum[45:14];

            s8_temp_reg  <= s7_temp_reg;
            s8_fine_reg  <= s7_fine_reg;
            s8_divx_reg  <= s7_xp_reg[63:33];
            s8_dvd_reg   <= s8_dvd_next;
            s8_hv_reg    <= s8_hv_next;

            s9_temp_reg  <= s8_temp_reg;
            s9_fine_reg  <= s8_fine_reg;
            s9_ua_reg    <= s8_dvd_reg[63] ? 64'd0 - s8_dvd_reg : s8_dvd_reg;
            s9_ub_reg    <= s8_divx_reg[30] ? 31'd0 - s8_divx_reg : s8_divx_reg;
            s9_neg_reg   <= s8_dvd_reg[63] ^ s8_divx_reg[30];
            s9_zero_reg  <= (s8_divx_reg == 31'd0);
            s9_hv_reg    <= s8_hv_reg;
            s9_qq_reg    <= s9_qq_full[32:0];

            s10_temp_reg <= s9_temp_reg;
            s10_fine_reg <= s9_fine_reg;
            s10_ua_reg   <= s9_ua_reg;
            s10_ub_reg   <= s9_ub_reg;
            s10_neg_reg  <= s9_neg_reg;
            s10_zero_reg <= s9_zero_reg;
            s10_hv_reg   <= s9_hv_reg;
            s10_hq_reg   <= s10_hq_next;

            dv_reg[0] <= s11_next;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                dv_reg[k] <= div_step(dv_reg[k-1]);
            end

            p1_p_reg     <= dv_last.neg ? 64'sd0 - $signed(dv_last.nq) : $signed(dv_last.nq);
            p1_temp_reg  <= dv_last.temp;
            p1_fine_reg  <= dv_last.fine;
            p1_hum_reg   <= dv_last.hum;
            p1_zero_reg  <= dv_last.zero;

            p2_p_reg     <= p1_p_reg;
            p2_y1a_reg   <= p2_y1a_next;
            p2_p8p_reg   <= p2_p8p_next;
            p2_temp_reg  <= p1_temp_reg;
            p2_fine_reg  <= p1_fine_reg;
            p2_hum_reg   <= p1_hum_reg;
            p2_zero_reg  <= p1_zero_reg;

            p3_p_reg     <= p2_p_reg;
            p3_p8p_reg   <= p2_p8p_reg;
            p3_pp0_reg   <= p2_y1a_reg[31:0] * p3_b64[31:0];
            p3_pp1_reg   <= p2_y1a_reg[63:32] * p3_b64[31:0];
            p3_pp2_reg   <= p2_y1a_reg[31:0] * p3_b64[63:32];
            p3_temp_reg  <= p2_temp_reg;
            p3_fine_reg  <= p2_fine_reg;
            p3_hum_reg   <= p2_hum_reg;
            p3_zero_reg  <= p2_zero_reg;

            p4_p_reg     <= p3_p_reg;
            p4_y1_reg    <= $signed(p4_y1full[63:25]);
            p4_y2_reg    <= $signed(p3_p8p_reg[63:19]);
            p4_temp_reg  <= p3_temp_reg;
            p4_fine_reg  <= p3_fine_reg;
            p4_hum_reg   <= p3_hum_reg;
            p4_zero_reg  <= p3_zero_reg;

            p5_r_reg     <= p5_r_next;
            p5_temp_reg  <= p4_temp_reg;
            p5_fine_reg  <= p4_fine_reg;
            p5_hum_reg   <= p4_hum_reg;
            p5_zero_reg  <= p4_zero_reg;

            out_press_reg  <= out_press_next;
            out_pvalid_reg <= !p5_zero_reg;
            out_temp_reg   <= p5_temp_reg;
            out_fine_reg   <= p5_fine_reg;
            out_hum_reg    <= p5_hum_reg;
        end
    end

    assign m_axis_tdata = {7'd0, out_hum_reg, out_press_reg,
                           {{8{out_fine_reg[23]}}, out_fine_reg},
                           {{13{out_temp_reg[18]}}, out_temp_reg}};
    assign m_axis_tuser = out_pvalid_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("Output word valid right after reset.");

    a_no_press_on_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[95:64] == 32'd0)
        else $error("Pressure not zero with zero divisor.");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[112:96] <= HUM_MAX_OUT)
        else $error("Humidity above full scale.");

    a_temp_matches_fine: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $signed(m_axis_tdata[31:0])
            == (($signed(m_axis_tdata[63:32]) * 40'sd5 + 40'sd128) >>> 8))
        else $error("Temperature and fine temperature from different words.");

endmodule

`default_nettype wire
